// File: hw/rtl/mav_pkg.sv
// mav_pkg: beat types and shared constants for the three-axis moving average
// used by mav_div and moving_average_3axis; no dependencies
`timescale 1ns / 1ps

package mav_pkg;

  // sample and average width, axes per beat
  localparam int SMP_W = 16;
  localparam int NAX   = 3;

  // default window length
  localparam int DEF_WINDOW = 20;

  // input beat: one gyro sample per axis
  typedef struct packed {
    logic signed [SMP_W-1:0] rate_x;
    logic signed [SMP_W-1:0] rate_y;
    logic signed [SMP_W-1:0] rate_z;
  } in_beat_t;

  // output beat: windowed average per axis
  typedef struct packed {
    logic signed [SMP_W-1:0] avg_x;
    logic signed [SMP_W-1:0] avg_y;
    logic signed [SMP_W-1:0] avg_z;
  } out_beat_t;

endpackage

// File: hw/rtl/moving_average_3axis.sv
// moving_average_3axis: three-axis boxcar average of gyro rates over WINDOW samples
// one ring memory of past samples plus running sums; uses mav_pkg and mav_div
//
//   channel | ports                          | beat        | direction
//   --------+--------------------------------+-------------+----------
//   input   | in_valid, in_stall, in_beat    | in_beat_t   | in
//   result  | out_valid, out_stall, out_beat | out_beat_t  | out
//
// One beat per cycle sustained while out_stall is low; a result is offered once its beat has passed
// the ring read, sum update and write back, reciprocal multiply and output register.
// Consecutive beats touch neighbouring ring entries, so no forwarding is needed.
// Synchronous active-low reset; ring entries not yet written read as zero via a lap flag.
// A stall at the output fills the pipeline stages in turn before in_stall rises.
`timescale 1ns / 1ps

module moving_average_3axis
  import mav_pkg::*;
#(
  parameter int WINDOW = DEF_WINDOW
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  localparam int PW    = $clog2(WINDOW);
  localparam int SUM_W = SMP_W + $clog2(WINDOW) + 1;
  localparam int EXT_W = SUM_W - SMP_W;

  // ring memory, all three axes side by side
  logic [NAX-1:0][SMP_W-1:0] ring_mem [WINDOW];

  logic [PW-1:0] wpos_r, wpos_nxt;
  logic          lap_r, lap_nxt;

  // stage 1: ring read in flight
  logic                      v1_r;
  logic [NAX-1:0][SMP_W-1:0] smp1_r;
  logic [NAX-1:0][SMP_W-1:0] old1_r;
  logic [PW-1:0]             pos1_r;
  logic                      lap1_r;

  // stage 2: updated sums
  logic                    v2_r;
  logic signed [SUM_W-1:0] sum2_r [NAX];
  logic signed [SUM_W-1:0] sum_r  [NAX];
  logic signed [SUM_W-1:0] sum_nxt [NAX];

  // stage 3: product inside the dividers
  logic                      v3_r;
  logic [NAX-1:0][SMP_W-1:0] quo;

  // output register
  logic                      out_valid_r;
  logic [NAX-1:0][SMP_W-1:0] out_r;

  logic acc, go1, go2, go3, free1, free2, free3, out_free;

  // pipeline advance chain
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    go3      = v3_r && out_free;
    free3    = !v3_r || go3;
    go2      = v2_r && free3;
    free2    = !v2_r || go2;
    go1      = v1_r && free2;
    free1    = !v1_r || go1;
    acc      = in_valid && free1;
  end

  assign in_stall  = !free1;
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  // write position and lap flag
  always_comb begin
    wpos_nxt = wpos_r;
    lap_nxt  = lap_r;
    if (acc) begin
      if (wpos_r == PW'(WINDOW - 1)) begin
        wpos_nxt = '0;
        lap_nxt  = 1'b1;
      end else begin
        wpos_nxt = wpos_r + 1'b1;
      end
    end
  end

  // new running sums: drop the oldest sample, add the new one
  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      logic signed [SUM_W-1:0] old_v;
      logic signed [SUM_W-1:0] new_v;
      old_v = lap1_r ? {{EXT_W{old1_r[k][SMP_W-1]}}, old1_r[k]} : '0;
      new_v = {{EXT_W{smp1_r[k][SMP_W-1]}}, smp1_r[k]};
      sum_nxt[k] = sum_r[k] - old_v + new_v;
    end
  end

  // ring read on accept, write back when stage 1 moves on
  always_ff @(posedge clk) begin
    if (acc) begin
      old1_r <= ring_mem[wpos_r];
    end
    if (go1) begin
      ring_mem[pos1_r] <= smp1_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r      <= '0;
      lap_r       <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NAX; k++) begin
        sum_r[k] <= '0;
      end
    end else begin
      wpos_r <= wpos_nxt;
      lap_r  <= lap_nxt;
      if (acc) begin
        v1_r <= 1'b1;
      end else if (go1) begin
        v1_r <= 1'b0;
      end
      if (go1) begin
        v2_r <= 1'b1;
      end else if (go2) begin
        v2_r <= 1'b0;
      end
      if (go2) begin
        v3_r <= 1'b1;
      end else if (go3) begin
        v3_r <= 1'b0;
      end
      if (go3) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (go1) begin
        for (int k = 0; k < NAX; k++) begin
          sum_r[k] <= sum_nxt[k];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      smp1_r <= in_beat;
      pos1_r <= wpos_r;
      lap1_r <= lap_r;
    end
    if (go1) begin
      for (int k = 0; k < NAX; k++) begin
        sum2_r[k] <= sum_nxt[k];
      end
    end
    if (go3) begin
      out_r <= quo;
    end
  end

  // one divider per axis
  for (genvar g = 0; g < NAX; g++) begin : g_div
    mav_div #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
    ) u_div (
      .clk   (clk),
      .ld    (go2),
      .sum_i (sum2_r[g]),
      .q_o   (quo[g])
    );
  end

  // write-back never lands on the entry being read
  a_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (go1 && acc) |-> (pos1_r != wpos_r))
    else $error("ring write and read hit the same entry");

  // write position stays inside the ring
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r <= PW'(WINDOW - 1))
    else $error("write position out of range");

  // once the ring has wrapped it stays filled
  a_lap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    lap_r |=> lap_r)
    else $error("lap flag dropped");

  // input held off only when the first stage is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

// File: hw/rtl/mav_div.sv
// mav_div: signed divide of a running sum by the window length, truncating toward zero
// reciprocal multiply on the magnitude, one register stage; uses mav_pkg
`timescale 1ns / 1ps

module mav_div
  import mav_pkg::*;
#(
  parameter int WINDOW = DEF_WINDOW,
  parameter int SUM_W  = SMP_W + $clog2(WINDOW) + 1
) (
  input  logic                    clk,
  input  logic                    ld,
  input  logic signed [SUM_W-1:0] sum_i,
  output logic        [SMP_W-1:0] q_o
);

  // magnitude bits, shift and exact reciprocal for magnitudes below 2**MAG_W
  localparam int MAG_W  = SUM_W - 1;
  localparam int SH     = MAG_W + $clog2(WINDOW);
  localparam int PROD_W = 2 * MAG_W + 1;
  localparam int Q_W    = PROD_W - SH;
  localparam logic [MAG_W:0] RECIP =
    (MAG_W+1)'(((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [SUM_W-1:0]  abs_v;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod_r;
  logic              neg_r;
  logic [Q_W-1:0]    quo;
  logic [Q_W-1:0]    res;

  // magnitude of the sum
  always_comb begin
    abs_v = sum_i[SUM_W-1] ? -sum_i : sum_i;
    mag   = abs_v[MAG_W-1:0];
  end

  // reciprocal multiply, registered
  always_ff @(posedge clk) begin
    if (ld) begin
      prod_r <= PROD_W'(mag) * PROD_W'(RECIP);
      neg_r  <= sum_i[SUM_W-1];
    end
  end

  // shift down and restore the sign
  always_comb begin
    quo = prod_r[PROD_W-1:SH];
    res = neg_r ? -quo : quo;
    q_o = res[SMP_W-1:0];
  end

endmodule
